// ----- hdl/mhap_pkg.sv -----
// ----------------------------------------------------------------------------
// MAC header parser package
// Word types, status codes, addressing constants and the header layout
// function shared by the parser modules.
// ----------------------------------------------------------------------------
package mhap_pkg;

    localparam int unsigned POS_W    = 7;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned MINLEN_W = 7;

    localparam logic [POS_W-1:0]    POS_MAX           = 7'd127;
    localparam logic [POS_W-1:0]    POS_SEQ           = 7'd2;
    localparam logic [POS_W-1:0]    MIN_HDR_BYTES     = 7'd2;
    localparam logic [MINLEN_W-1:0] MIN_FRAME_LEN_RST = 7'd6;
    localparam logic [2:0]          FRAME_TYPE_UNSUP  = 3'h5;

    localparam logic [1:0] MODE_NONE  = 2'h0;
    localparam logic [1:0] MODE_BYTE  = 2'h1;
    localparam logic [1:0] MODE_SHORT = 2'h2;
    localparam logic [1:0] MODE_LONG  = 2'h3;
    localparam logic [1:0] VERSION_0  = 2'h0;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_ADDR  = 3'd1,
        ST_TYPE_5   = 3'd2,
        ST_BAD_MODE = 3'd3,
        ST_SHORT    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [15:0]      frame_control;
        logic [7:0]       seq_number;
        logic [15:0]      dst_pan_id;
        logic [63:0]      dest_addr;
        logic [15:0]      src_pan;
        logic [63:0]      src_addr;
        logic [LEN_W-1:0] header_length;
    } t_out_word;

    typedef struct packed {
        logic             report;
        logic [POS_W-1:0] count;
        logic [15:0]      cw;
        logic [7:0]       seq;
        logic [15:0]      dpan;
        logic [63:0]      dadr;
        logic [15:0]      span;
        logic [63:0]      sadr;
    } t_frame_state;

    typedef struct packed {
        logic [LEN_W-1:0] seq_len;
        logic [LEN_W-1:0] dpan_off;
        logic [LEN_W-1:0] dpan_len;
        logic [LEN_W-1:0] dadr_off;
        logic [LEN_W-1:0] dadr_len;
        logic [LEN_W-1:0] span_off;
        logic [LEN_W-1:0] span_len;
        logic [LEN_W-1:0] sadr_off;
        logic [LEN_W-1:0] sadr_len;
        logic [LEN_W-1:0] total;
    } t_layout;

    function automatic logic [LEN_W-1:0] mode_len(input logic [1:0] mode);
        logic [LEN_W-1:0] len;
        case (mode)
            MODE_NONE:  len = 5'd0;
            MODE_BYTE:  len = 5'd1;
            MODE_SHORT: len = 5'd2;
            MODE_LONG:  len = 5'd8;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic t_layout make_layout(input logic [15:0] cw);
        t_layout    l;
        logic [1:0] dmode;
        logic [1:0] smode;
        dmode      = cw[11:10];
        smode      = cw[15:14];
        l.seq_len  = cw[8] ? 5'd0 : 5'd1;
        l.dpan_off = 5'd2 + l.seq_len;
        l.dpan_len = (dmode >= MODE_SHORT) ? 5'd2 : 5'd0;
        l.dadr_off = l.dpan_off + l.dpan_len;
        l.dadr_len = mode_len(dmode);
        l.span_off = l.dadr_off + l.dadr_len;
        l.span_len = (smode >= MODE_SHORT && !cw[6]) ? 5'd2 : 5'd0;
        l.sadr_off = l.span_off + l.span_len;
        l.sadr_len = mode_len(smode);
        l.total    = l.sadr_off + l.sadr_len;
        return l;
    endfunction

endpackage

// ----- hdl/mhap_capture.sv -----
// ----------------------------------------------------------------------------
// MAC header field capture
// Holds the per-frame state and places each accepted byte into the field
// that its position selects.
// ----------------------------------------------------------------------------
module mhap_capture (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  mhap_pkg::t_in_word  i_word,
    output mhap_pkg::t_frame_state o_next
);
    import mhap_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_cw;
    logic [7:0]       r_seq;
    logic [15:0]      r_dpan;
    logic [63:0]      r_dadr;
    logic [15:0]      r_span;
    logic [63:0]      r_sadr;
    logic             r_done;

    logic [POS_W-1:0] base_pos;
    logic [15:0]      base_cw;
    logic             base_done;
    logic             take;
    t_layout          lay;
    logic [LEN_W-1:0] p5;
    logic [LEN_W-1:0] dpan_idx;
    logic [LEN_W-1:0] dadr_idx;
    logic [LEN_W-1:0] span_idx;
    logic [LEN_W-1:0] sadr_idx;
    logic             in_dpan;
    logic             in_dadr;
    logic             in_span;
    logic             in_sadr;
    logic [7:0]       b;
    t_frame_state     n_st;

    always_comb begin
        b         = i_word.data_byte;
        base_pos  = i_word.first_byte ? '0 : r_pos;
        base_cw   = i_word.first_byte ? '0 : r_cw;
        base_done = i_word.first_byte ? 1'b0 : r_done;
        take      = i_accept && !base_done;
        lay       = make_layout(base_cw);
        p5        = base_pos[LEN_W-1:0];
        dpan_idx  = p5 - lay.dpan_off;
        dadr_idx  = p5 - lay.dadr_off;
        span_idx  = p5 - lay.span_off;
        sadr_idx  = p5 - lay.sadr_off;
        in_dpan   = base_pos >= {2'b00, lay.dpan_off}
                    && base_pos < {2'b00, lay.dpan_off + lay.dpan_len};
        in_dadr   = base_pos >= {2'b00, lay.dadr_off}
                    && base_pos < {2'b00, lay.dadr_off + lay.dadr_len};
        in_span   = base_pos >= {2'b00, lay.span_off}
                    && base_pos < {2'b00, lay.span_off + lay.span_len};
        in_sadr   = base_pos >= {2'b00, lay.sadr_off}
                    && base_pos < {2'b00, lay.sadr_off + lay.sadr_len};

        n_st.cw   = base_cw;
        n_st.seq  = i_word.first_byte ? '0 : r_seq;
        n_st.dpan = i_word.first_byte ? '0 : r_dpan;
        n_st.dadr = i_word.first_byte ? '0 : r_dadr;
        n_st.span = i_word.first_byte ? '0 : r_span;
        n_st.sadr = i_word.first_byte ? '0 : r_sadr;

        if (base_pos < MIN_HDR_BYTES) begin
            if (base_pos[0]) begin
                n_st.cw[15:8] = base_cw[15:8] | b;
            end else begin
                n_st.cw[7:0] = base_cw[7:0] | b;
            end
        end else if (lay.seq_len != '0 && base_pos == POS_SEQ) begin
            n_st.seq = b;
        end else if (in_dpan) begin
            if (dpan_idx[0]) begin
                n_st.dpan[15:8] = n_st.dpan[15:8] | b;
            end else begin
                n_st.dpan[7:0] = n_st.dpan[7:0] | b;
            end
        end else if (in_dadr) begin
            n_st.dadr[8*dadr_idx[2:0] +: 8] = n_st.dadr[8*dadr_idx[2:0] +: 8] | b;
        end else if (in_span) begin
            if (span_idx[0]) begin
                n_st.span[15:8] = n_st.span[15:8] | b;
            end else begin
                n_st.span[7:0] = n_st.span[7:0] | b;
            end
        end else if (in_sadr) begin
            n_st.sadr[8*sadr_idx[2:0] +: 8] = n_st.sadr[8*sadr_idx[2:0] +: 8] | b;
        end

        n_st.count  = (base_pos != POS_MAX) ? base_pos + 7'd1 : base_pos;
        n_st.report = take && i_word.last_byte;
        o_next      = n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cw   <= '0;
            r_seq  <= '0;
            r_dpan <= '0;
            r_dadr <= '0;
            r_span <= '0;
            r_sadr <= '0;
            r_done <= 1'b0;
        end else if (take) begin
            r_pos  <= n_st.count;
            r_cw   <= n_st.cw;
            r_seq  <= n_st.seq;
            r_dpan <= n_st.dpan;
            r_dadr <= n_st.dadr;
            r_span <= n_st.span;
            r_sadr <= n_st.sadr;
            r_done <= i_word.last_byte;
        end
    end

endmodule

// ----- hdl/mhap_eval.sv -----
// ----------------------------------------------------------------------------
// MAC header status evaluation
// Checks the finished frame against the minimum length, the frame type, the
// addressing modes and the header layout and forms the result word.
// ----------------------------------------------------------------------------
module mhap_eval (
    input  mhap_pkg::t_frame_state          i_state,
    input  logic [mhap_pkg::MINLEN_W-1:0]   i_min_len,
    output mhap_pkg::t_out_word             o_word
);
    import mhap_pkg::*;

    t_layout    lay;
    t_status    st;
    logic [1:0] dmode;
    logic [1:0] smode;
    logic [1:0] ver;

    always_comb begin
        lay   = make_layout(i_state.cw);
        dmode = i_state.cw[11:10];
        smode = i_state.cw[15:14];
        ver   = i_state.cw[13:12];

        if (i_state.count < i_min_len || i_state.count < MIN_HDR_BYTES) begin
            st = ST_SHORT;
        end else if (i_state.cw[2:0] == FRAME_TYPE_UNSUP) begin
            st = ST_TYPE_5;
        end else if (ver == VERSION_0 && (dmode == MODE_BYTE || smode == MODE_BYTE)) begin
            st = ST_BAD_MODE;
        end else if (i_state.count < {2'b00, lay.total}) begin
            st = ST_SHORT;
        end else if (dmode < MODE_SHORT && smode < MODE_SHORT) begin
            st = ST_NO_ADDR;
        end else begin
            st = ST_OK;
        end

        o_word               = '0;
        o_word.status        = st;
        o_word.frame_control = i_state.cw;
        if (st == ST_OK || st == ST_NO_ADDR) begin
            o_word.seq_number    = i_state.seq;
            o_word.dst_pan_id    = i_state.dpan;
            o_word.dest_addr     = i_state.dadr;
            o_word.src_pan       = i_state.cw[6] ? i_state.dpan : i_state.span;
            o_word.src_addr      = i_state.sadr;
            o_word.header_length = lay.total;
        end
    end

endmodule

// ----- hdl/mhap_skid.sv -----
// ----------------------------------------------------------------------------
// MAC header result buffer
// Output register with one skid entry so that input bytes keep flowing
// while a result waits downstream.
// ----------------------------------------------------------------------------
module mhap_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mhap_pkg::t_out_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output mhap_pkg::t_out_word o_word
);
    import mhap_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_word r_out;
    t_out_word r_skid;
    logic      drain;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;
    assign drain   = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_word;
            end
        end else if (i_valid) begin
            r_skid <= i_word;
        end
    end

endmodule

// ----- hdl/mac_header_address_parser.sv -----
// ----------------------------------------------------------------------------
// MAC header address parser
// Parses an IEEE 802.15.4 MAC header from a byte stream into its fields.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle with no gaps required. A byte with
// first_byte set starts a new frame, and the byte with last_byte set closes
// it and produces exactly one result word, held in the output register or
// its skid entry. Bytes that arrive after a closed frame and before the next
// first_byte are taken and dropped. The output register has one skid entry
// behind it, so input stalls only when two results are waiting. The user must
// write the minimum frame length through the configuration port only while
// the block is idle; the block does not enforce this. It resets to six bytes.
module mac_header_address_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mhap_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mhap_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_wr_en,
    input  logic [mhap_pkg::MINLEN_W-1:0]    i_cfg_wr_data
);
    import mhap_pkg::*;

    logic [MINLEN_W-1:0] r_min_len;
    t_frame_state        next_state;
    t_out_word           res_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_FRAME_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_min_len <= i_cfg_wr_data;
        end
    end

    mhap_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && o_in_ready),
        .i_word   (i_in_word),
        .o_next   (next_state)
    );

    mhap_eval u_eval (
        .i_state   (next_state),
        .i_min_len (r_min_len),
        .o_word    (res_word)
    );

    mhap_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (next_state.report),
        .i_word  (res_word),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// ----- hdl/mhap_checker.sv -----
// ----------------------------------------------------------------------------
// MAC header parser checker
// Port-level assertions on the result stream of the parser.
// ----------------------------------------------------------------------------
module mhap_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mhap_pkg::t_out_word o_out_word
);
    import mhap_pkg::*;

    logic is_err;
    logic is_good;

    assign is_err  = o_out_word.status == ST_TYPE_5 || o_out_word.status == ST_BAD_MODE
                     || o_out_word.status == ST_SHORT;
    assign is_good = o_out_word.status == ST_OK || o_out_word.status == ST_NO_ADDR;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && is_err |-> o_out_word.header_length == '0
            && o_out_word.seq_number == '0 && o_out_word.dest_addr == '0
            && o_out_word.src_addr == '0 && o_out_word.src_pan == '0)
        else $error("error result carries field data");

    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && is_good |-> o_out_word.header_length >= 5'd2
            && o_out_word.header_length <= 5'd23)
        else $error("header length out of range");

    a_pan_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.frame_control[6] |-> o_out_word.src_pan
            == o_out_word.dst_pan_id)
        else $error("compressed source PAN differs from destination PAN");

endmodule

bind mac_header_address_parser mhap_checker u_mhap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
